// ===== hdl/phk_pkg.sv =====
// Shared types and constants for the per-key repeat holdoff block.
// No dependencies; imported by phk_alu, the core and both bench files.
`timescale 1ns / 1ps
package phk_pkg;

    localparam int PHK_FILTERS_DEF = 4;
    localparam int PHK_WORD_REGS   = 4;
    localparam int PHK_CNT_W       = 3;
    localparam int PHK_ADDR_W      = 5;
    localparam int PHK_DATA_W      = 32;

    localparam logic [1:0] KIND_TEST  = 2'd0;
    localparam logic [1:0] KIND_TIME  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] REG_COUNT  = 3'd0;
    localparam logic [2:0] REG_WORD0  = 3'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  key;
        logic [1:0]  key_type;
        logic [15:0] elapsed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] key_out;
        logic       passed;
    } out_item_t;

    typedef struct packed {
        logic [15:0] ticks;
        logic [1:0]  key_type;
        logic [7:0]  key;
    } filter_word_t;

    typedef struct packed {
        logic        match;
        logic        expire;
        logic [15:0] diff;
    } unit_res_t;

endpackage

// ===== hdl/phk_alu.sv =====
// Shared compare and subtract unit used by the holdoff sequencer's scans.
// Depends on phk_pkg.
`timescale 1ns / 1ps
module phk_alu
    import phk_pkg::*;
(
    input  logic [7:0]  a_key,
    input  logic [1:0]  a_type,
    input  logic [7:0]  b_key,
    input  logic [1:0]  b_type,
    input  logic [15:0] remaining,
    input  logic [15:0] elapsed,
    output unit_res_t   res
);

    always_comb
    begin
        res.match  = (a_key == b_key) && (a_type == b_type);
        res.expire = (remaining <= elapsed);
        res.diff   = remaining - elapsed;
    end

endmodule

// ===== hdl/per_key_repeat_holdoff_core.sv =====
// Top level of the per-key repeat holdoff block: APB register file, slot store, sequencer.
// Depends on phk_pkg and phk_alu.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; busy stays high while the
// sequencer steps one slot or filter per cycle through the shared compare/subtract
// unit. A test item runs a holdoff scan, then a filter scan and free-slot search as
// needed, and ends with one result on result for one cycle, marked by strobe. A time
// item steps through every slot, a clear item leaves busy low; neither gives a
// result. The receiver cannot stall: results must be taken on the cycle they appear.
module per_key_repeat_holdoff_core
    import phk_pkg::*;
#(
    parameter int FILTERS = PHK_FILTERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  strobe,
    output out_item_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PHK_ADDR_W-1:0] paddr,
    input  logic [PHK_DATA_W-1:0] pwdata,
    output logic [PHK_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IW = (FILTERS > 1) ? $clog2(FILTERS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HOLD = 3'd1;
    localparam logic [2:0] S_FILT = 3'd2;
    localparam logic [2:0] S_FREE = 3'd3;
    localparam logic [2:0] S_TIME = 3'd4;

    logic [PHK_CNT_W-1:0] count_reg;
    filter_word_t         word_q [FILTERS];

    logic [2:0]   reg_idx;
    logic         wr_en;

    logic [2:0]   state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic         strobe_reg, strobe_next;
    out_item_t    result_reg, result_next;
    in_item_t     item_reg;
    logic [15:0]  ticks_reg, ticks_next;
    logic [FILTERS-1:0] valid_reg, valid_next;
    logic [7:0]   hkey_reg  [FILTERS];
    logic [1:0]   htype_reg [FILTERS];
    logic [15:0]  hrem_reg  [FILTERS];

    logic         arm_en, upd_en, accept;
    logic [PHK_CNT_W-1:0] n_used;
    logic         idx_last, filt_last;
    logic [7:0]   b_key;
    logic [1:0]   b_type;
    unit_res_t    ures;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign result  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en && reg_idx == REG_COUNT)
        begin
            count_reg <= pwdata[PHK_CNT_W-1:0];
        end
    end

    for (genvar g = 0; g < FILTERS; g++)
    begin : g_word
        if (g < PHK_WORD_REGS)
        begin : g_reg
            filter_word_t word_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    word_reg <= '0;
                end
                else if (wr_en && reg_idx == REG_WORD0 + 3'(g))
                begin
                    word_reg <= pwdata[$bits(filter_word_t)-1:0];
                end
            end
            assign word_q[g] = word_reg;
        end
        else
        begin : g_zero
            assign word_q[g] = '0;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_COUNT)
        begin
            prdata = PHK_DATA_W'(count_reg);
        end
        else if (reg_idx >= REG_WORD0 && reg_idx < REG_WORD0 + 3'(PHK_WORD_REGS))
        begin
            for (int w = 0; w < FILTERS; w++)
            begin
                if (w < PHK_WORD_REGS && reg_idx == REG_WORD0 + 3'(w))
                begin
                    prdata = PHK_DATA_W'(word_q[w]);
                end
            end
        end
    end

    assign n_used    = (count_reg > PHK_CNT_W'(FILTERS)) ? PHK_CNT_W'(FILTERS) : count_reg;
    assign idx_last  = (idx_reg == IW'(FILTERS - 1));
    assign filt_last = (PHK_CNT_W'(idx_reg) == n_used - 1'b1);

    always_comb
    begin
        if (state_reg == S_FILT)
        begin
            b_key  = word_q[idx_reg].key;
            b_type = word_q[idx_reg].key_type;
        end
        else
        begin
            b_key  = hkey_reg[idx_reg];
            b_type = htype_reg[idx_reg];
        end
    end

    phk_alu u_alu (
        .a_key     (item_reg.key),
        .a_type    (item_reg.key_type),
        .b_key     (b_key),
        .b_type    (b_type),
        .remaining (hrem_reg[idx_reg]),
        .elapsed   (item_reg.elapsed),
        .res       (ures)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        ticks_next  = ticks_reg;
        valid_next  = valid_reg;
        arm_en      = 1'b0;
        upd_en      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    case (item.kind)
                        KIND_TEST:  state_next = S_HOLD;
                        KIND_TIME:  state_next = S_TIME;
                        KIND_CLEAR: valid_next = '0;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_HOLD:
            begin
                result_next.key_out = item_reg.key;
                if (valid_reg[idx_reg] && ures.match)
                begin
                    result_next.passed = 1'b0;
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (idx_last)
                begin
                    idx_next = '0;
                    if (n_used == '0)
                    begin
                        result_next.passed = 1'b1;
                        strobe_next        = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FILT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_FILT:
            begin
                result_next.passed = 1'b1;
                if (ures.match)
                begin
                    ticks_next = word_q[idx_reg].ticks;
                    idx_next   = '0;
                    state_next = S_FREE;
                end
                else if (filt_last)
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    arm_en              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    strobe_next         = 1'b1;
                    state_next          = S_IDLE;
                end
                else if (idx_last)
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_TIME:
            begin
                if (valid_reg[idx_reg])
                begin
                    if (ures.expire)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        upd_en = 1'b1;
                    end
                end
                if (idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        ticks_reg  <= ticks_next;
        if (accept)
        begin
            item_reg <= item;
        end
        if (arm_en)
        begin
            hkey_reg[idx_reg]  <= item_reg.key;
            htype_reg[idx_reg] <= item_reg.key_type;
            hrem_reg[idx_reg]  <= ticks_reg;
        end
        else if (upd_en)
        begin
            hrem_reg[idx_reg] <= ures.diff;
        end
    end

endmodule

// ===== tb/phk_holdoff_checker.sv =====
`timescale 1ns / 1ps
// Checker for per_key_repeat_holdoff_core: snoops APB transfers, predicts the result of
// every accepted test item and compares strobed results in order. Depends on phk_pkg.
module phk_holdoff_checker
    import phk_pkg::*;
#(
    parameter int FILTERS = PHK_FILTERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  in_item_t              item,
    input  logic                  strobe,
    input  out_item_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PHK_ADDR_W-1:0] paddr,
    input  logic [PHK_DATA_W-1:0] pwdata,
    input  logic [PHK_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    errors,
    output int                    outstanding
);

    logic [PHK_CNT_W-1:0] cfg_count;
    filter_word_t         cfg_word [FILTERS];
    bit                   slot_live [FILTERS];
    logic [7:0]           slot_key [FILTERS];
    logic [1:0]           slot_type [FILTERS];
    logic [15:0]          slot_left [FILTERS];
    out_item_t            due_results [$];
    out_item_t            want;

    task automatic flag_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic write_reg(input logic [PHK_ADDR_W-1:0] addr, input logic [PHK_DATA_W-1:0] data);
        int idx;
        idx = int'(addr[PHK_ADDR_W-1:2]);
        if (idx == int'(REG_COUNT))
            cfg_count = data[PHK_CNT_W-1:0];
        else if (idx >= int'(REG_WORD0) && idx < int'(REG_WORD0) + PHK_WORD_REGS
                 && idx - int'(REG_WORD0) < FILTERS)
            cfg_word[idx - int'(REG_WORD0)] = data[25:0];
    endtask

    task automatic check_read(input logic [PHK_ADDR_W-1:0] addr, input logic [PHK_DATA_W-1:0] data);
        int idx;
        logic [PHK_DATA_W-1:0] reg_val;
        bit known;
        idx = int'(addr[PHK_ADDR_W-1:2]);
        known = 1'b1;
        reg_val = '0;
        if (idx == int'(REG_COUNT))
            reg_val = PHK_DATA_W'(cfg_count);
        else if (idx >= int'(REG_WORD0) && idx < int'(REG_WORD0) + PHK_WORD_REGS
                 && idx - int'(REG_WORD0) < FILTERS)
            reg_val = PHK_DATA_W'(cfg_word[idx - int'(REG_WORD0)]);
        else
            known = 1'b0;
        if (known && data !== reg_val)
            flag_error($sformatf("register %0d read %0h, expected %0h", idx, data, reg_val));
    endtask

    task automatic predict_holdoff(input in_item_t it);
        out_item_t res;
        bit blocked;
        bit matched;
        bit armed;
        int i;
        int s;
        int n;
        case (it.kind)
            KIND_TEST:
            begin
                blocked = 1'b0;
                for (i = 0; i < FILTERS; i++)
                    if (slot_live[i] && slot_key[i] == it.key && slot_type[i] == it.key_type)
                        blocked = 1'b1;
                if (!blocked)
                begin
                    n = (int'(cfg_count) > FILTERS) ? FILTERS : int'(cfg_count);
                    matched = 1'b0;
                    for (i = 0; i < n; i++)
                    begin
                        if (!matched && cfg_word[i].key == it.key
                            && cfg_word[i].key_type == it.key_type)
                        begin
                            matched = 1'b1;
                            armed = 1'b0;
                            for (s = 0; s < FILTERS; s++)
                            begin
                                if (!armed && !slot_live[s])
                                begin
                                    armed = 1'b1;
                                    slot_live[s] = 1'b1;
                                    slot_key[s] = it.key;
                                    slot_type[s] = it.key_type;
                                    slot_left[s] = cfg_word[i].ticks;
                                end
                            end
                        end
                    end
                end
                res.key_out = it.key;
                res.passed = !blocked;
                due_results.insert(due_results.size(), res);
            end
            KIND_TIME:
            begin
                for (i = 0; i < FILTERS; i++)
                begin
                    if (slot_live[i])
                    begin
                        if (slot_left[i] <= it.elapsed)
                        begin
                            slot_live[i] = 1'b0;
                            slot_left[i] = '0;
                        end
                        else
                            slot_left[i] = slot_left[i] - it.elapsed;
                    end
                end
            end
            KIND_CLEAR:
            begin
                for (i = 0; i < FILTERS; i++)
                    slot_live[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count = '0;
            for (int i = 0; i < FILTERS; i++)
            begin
                cfg_word[i] = '0;
                slot_live[i] = 1'b0;
                slot_key[i] = '0;
                slot_type[i] = '0;
                slot_left[i] = '0;
            end
            due_results.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                    write_reg(paddr, pwdata);
                else
                    check_read(paddr, prdata);
            end
            if (strobe)
            begin
                if (due_results.size() == 0)
                    flag_error($sformatf("result for key %0h with nothing pending",
                                         result.key_out));
                else
                begin
                    want = due_results.pop_front();
                    if (result.key_out !== want.key_out)
                        flag_error($sformatf("key_out %0h, expected %0h",
                                             result.key_out, want.key_out));
                    if (result.passed !== want.passed)
                        flag_error($sformatf("passed %0b for key %0h, expected %0b",
                                             result.passed, want.key_out, want.passed));
                end
            end
            if (start && !busy)
                predict_holdoff(item);
        end
        outstanding = due_results.size();
    end

endmodule

// ===== tb/tb_per_key_repeat_holdoff_core.sv =====
`timescale 1ns / 1ps
// Testbench top for per_key_repeat_holdoff_core: drives directed and random key, time and
// clear items across several filter setups and gives the verdict. Depends on phk_pkg,
// per_key_repeat_holdoff_core and phk_holdoff_checker.
module tb_per_key_repeat_holdoff_core;
    import phk_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 3 * PHK_FILTERS_DEF + 8;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 222;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_item_t              item;
    logic                  strobe;
    out_item_t             result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PHK_ADDR_W-1:0] paddr;
    logic [PHK_DATA_W-1:0] pwdata;
    logic [PHK_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    outstanding;

    bit                    steady;
    bit                    paused;
    filter_word_t          cur_word [PHK_WORD_REGS];
    int                    phase_count [PHASES] = '{1, 0, 7, 2, 3, 5, 4, 4};
    int                    sent;
    in_item_t              nxt;

    per_key_repeat_holdoff_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    phk_holdoff_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .strobe      (strobe),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("per_key_repeat_holdoff_core: mismatch");
        $finish;
    end

    function automatic in_item_t mk(input logic [1:0] kind, input logic [7:0] key,
                                    input logic [1:0] key_type, input logic [15:0] elapsed);
        in_item_t it;
        it.kind = kind;
        it.key = key;
        it.key_type = key_type;
        it.elapsed = elapsed;
        return it;
    endfunction

    function automatic logic [15:0] pick_ticks();
        int s;
        s = $urandom_range(0, 99);
        if (s < 15)
            return 16'd0;
        else if (s < 75)
            return 16'($urandom_range(1, 60));
        else if (s < 95)
            return 16'($urandom_range(61, 3000));
        return 16'($urandom);
    endfunction

    function automatic in_item_t pick_item();
        in_item_t it;
        int r;
        int s;
        int w;
        it = mk(KIND_TEST, 8'($urandom), 2'($urandom), 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 60 || r >= 96)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                w = $urandom_range(0, PHK_WORD_REGS - 1);
                it.key = cur_word[w].key;
                it.key_type = cur_word[w].key_type;
            end
        end
        else if (r < 90)
        begin
            it.kind = KIND_TIME;
            s = $urandom_range(0, 99);
            if (s < 20)
                it.elapsed = 16'd0;
            else if (s < 80)
                it.elapsed = 16'($urandom_range(1, 40));
            else if (s < 95)
                it.elapsed = 16'($urandom_range(41, 2000));
        end
        else if (r < 93)
            it.kind = KIND_CLEAR;
        else
            it.kind = KIND_SPARE;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int n;
        if (!steady && $urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_quiet();
        do
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        while (outstanding != 0 || busy);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input int idx, input logic [PHK_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PHK_ADDR_W'(idx * 4);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_word(input int i, input filter_word_t w);
        cur_word[i] = w;
        apb_transfer(1'b1, int'(REG_WORD0) + i, {6'($urandom), w});
    endtask

    task automatic read_back();
        for (int i = 0; i <= PHK_WORD_REGS; i++)
            apb_transfer(1'b0, i, '0);
    endtask

    task automatic load_filters(input int cnt, input int p);
        filter_word_t w;
        wait_quiet();
        apb_transfer(1'b1, int'(REG_COUNT), {29'($urandom), 3'(cnt)});
        for (int i = 0; i < PHK_WORD_REGS; i++)
        begin
            if (p == 3)
                w = '0;
            else if (p == 6)
                w = '1;
            else
            begin
                w.key = 8'($urandom);
                w.key_type = 2'($urandom);
                w.ticks = pick_ticks();
                if (i > 0 && $urandom_range(0, 99) < 30)
                begin
                    w.key = cur_word[i - 1].key;
                    w.key_type = cur_word[i - 1].key_type;
                end
            end
            set_word(i, w);
        end
        for (int i = PHK_WORD_REGS + 1; i < (1 << (PHK_ADDR_W - 2)); i++)
            apb_transfer(1'b1, i, $urandom);
        read_back();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        paused = 1'b0;
        for (int i = 0; i < PHK_WORD_REGS; i++)
            cur_word[i] = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_quiet();
        read_back();

        apb_transfer(1'b1, int'(REG_COUNT), 32'd4);
        set_word(0, {16'd0, 2'd0, 8'h00});
        set_word(1, {16'hFFFF, 2'd3, 8'hFF});
        set_word(2, {16'd5, 2'd1, 8'h10});
        set_word(3, {16'd9, 2'd1, 8'h10});
        read_back();

        send_item(mk(KIND_TEST, 8'h00, 2'd0, 16'hFFFF));
        send_item(mk(KIND_TEST, 8'h00, 2'd0, 16'd0));
        send_item(mk(KIND_TIME, 8'hFF, 2'd3, 16'd0));
        send_item(mk(KIND_TEST, 8'h00, 2'd0, 16'd0));
        send_item(mk(KIND_TEST, 8'hFF, 2'd3, 16'd0));
        send_item(mk(KIND_TEST, 8'h10, 2'd1, 16'd0));
        send_item(mk(KIND_TEST, 8'h10, 2'd1, 16'd0));
        send_item(mk(KIND_TIME, 8'h00, 2'd0, 16'd4));
        send_item(mk(KIND_TEST, 8'h10, 2'd1, 16'd0));
        send_item(mk(KIND_TIME, 8'h00, 2'd0, 16'd1));
        send_item(mk(KIND_TEST, 8'h10, 2'd1, 16'd0));
        send_item(mk(KIND_TEST, 8'h10, 2'd2, 16'd0));
        send_item(mk(KIND_TEST, 8'h55, 2'd0, 16'd0));
        send_item(mk(KIND_TEST, 8'hFF, 2'd3, 16'd0));
        send_item(mk(KIND_CLEAR, 8'hAA, 2'd2, 16'h5555));
        send_item(mk(KIND_TEST, 8'hFF, 2'd3, 16'd0));
        send_item(mk(KIND_SPARE, 8'hFF, 2'd3, 16'hFFFF));
        send_item(mk(KIND_TEST, 8'hFF, 2'd3, 16'd0));
        send_item(mk(KIND_TIME, 8'h00, 2'd0, 16'hFFFF));
        send_item(mk(KIND_TEST, 8'hFF, 2'd3, 16'hFFFF));
        send_item(mk(KIND_TEST, 8'h00, 2'd0, 16'd0));
        send_item(mk(KIND_TEST, 8'hFF, 2'd0, 16'd0));

        for (int p = 0; p < PHASES; p++)
        begin
            load_filters(phase_count[p], p);
            steady = (p == 4);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                nxt = pick_item();
                send_item(nxt);
                if (nxt.kind != KIND_SPARE)
                    sent++;
                if (p == 2 && sent == PHASE_ITEMS / 2 && !paused)
                begin
                    paused = 1'b1;
                    wait_quiet();
                end
            end
        end

        wait_quiet();
        if (errors == 0)
            $display("per_key_repeat_holdoff_core: match");
        else
            $display("per_key_repeat_holdoff_core: mismatch");
        $finish;
    end

endmodule

// ===== per_key_repeat_holdoff_core.f =====
hdl/phk_pkg.sv
hdl/phk_alu.sv
hdl/per_key_repeat_holdoff_core.sv
tb/phk_holdoff_checker.sv
tb/tb_per_key_repeat_holdoff_core.sv
